// ----- hdl/line_blob_centroid_tracker_top_macros.svh -----
// Assertion macros for the blob centroid tracker
`ifndef LINE_BLOB_CENTROID_TRACKER_TOP_MACROS_SVH
`define LINE_BLOB_CENTROID_TRACKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LBCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LBCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/lbct_pkg.sv -----
// Shared types and constants of the blob centroid tracker
`default_nettype none
package lbct_pkg;

  localparam int MAP_ENTRIES     = 16;
  localparam int SEGMENT_ENTRIES = 64;
  localparam int LINE_PIXELS     = 1024;

  localparam int MAP_IW = $clog2(MAP_ENTRIES);
  localparam int MAP_CW = $clog2(MAP_ENTRIES + 1);
  localparam int SEG_IW = $clog2(SEGMENT_ENTRIES);
  localparam int SEG_CW = $clog2(SEGMENT_ENTRIES + 1);
  localparam int LP_W   = 13;

  localparam int COL_W  = 10;
  localparam int RUN_W  = 11;
  localparam int RSUM_W = RUN_W + COL_W;
  localparam int XC_W   = 14;
  localparam int SUM_W  = XC_W + SEG_CW;
  localparam int DIV_NW = RSUM_W + 4;
  localparam int DIV_DW = RUN_W;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_EOF   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH      = 2'd0,
    REG_SAMPLE_INTERVAL = 2'd1,
    REG_PIXEL_THRESHOLD = 2'd2,
    REG_MAX_GAP         = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_CHECK, ST_MOD_WAIT, ST_PIXEL, ST_XC_WAIT,
    ST_MATCH_RD, ST_MATCH_EV, ST_PLACE, ST_SEG,
    ST_ACC_SEG_RD, ST_ACC_MAP_RD, ST_ACC_RD, ST_ACC_WR,
    ST_EMIT_RD, ST_EMIT_CHK, ST_DIVX_WAIT, ST_DIVY_WAIT, ST_OUT, ST_OUT_EMPTY
  } state_e;

  typedef struct packed {
    logic [MAP_IW-1:0] p;
    logic              act;
    logic              sole;
    logic [XC_W-1:0]   x;
    logic [RUN_W-1:0]  w;
    logic [9:0]        y;
  } map_ent_t;

  typedef struct packed {
    logic [MAP_IW-1:0] i;
    logic [9:0]        l;
    logic [XC_W-1:0]   x;
    logic [RUN_W-1:0]  w;
  } seg_ent_t;

  typedef struct packed {
    logic [15:0]       mass;
    logic [SEG_CW-1:0] n;
    logic [SUM_W-1:0]  sx;
    logic [SUM_W-1:0]  sy;
  } acc_ent_t;

  typedef struct packed {
    logic take;
    logic drop_ls;
    logic clear_all;
    logic mod_start;
    logic pix_apply;
    logic xc_start;
    logic drop_run;
    logic match_init;
    logic match_rd;
    logic match_ev;
    logic place;
    logic seg_wr;
    logic acc_init;
    logic acc_seg_rd;
    logic acc_map_rd;
    logic acc_rd;
    logic acc_wr;
    logic emit_rd;
    logic divx_start;
    logic divy_start;
    logic out_load;
    logic out_empty;
    logic clear_blobs;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  col_ok;
    logic  div_done;
    logic  mod_zero;
    logic  closing;
    logic  run_empty;
    logic  match_more;
    logic  place_ok;
    logic  acc_more;
    logic  count_zero;
    logic  emit_more;
    logic  emit_vld;
    logic  out_free;
    logic  last_res;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/line_blob_centroid_tracker_top.sv -----
// Pixel sample: dropped early when off the grid; otherwise a grid check on the divider, and
// when a run closes a divide for its centre, then a scan of the blob map entries.
// End of frame: each stored segment is accumulated, then 2 divides per blob.
// One item at a time; all divides share one bit-serial divider.
// Results sit in an output register; the next item is taken while one waits.
// Reset: asynchronous, active low; clears control, config to defaults, no store sweep.
`default_nettype none
`include "line_blob_centroid_tracker_top_macros.svh"
module line_blob_centroid_tracker_top
  import lbct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  pixel_i,
  input  wire logic [9:0]  column_i,
  input  wire logic [9:0]  line_i,
  input  wire logic        line_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [13:0]      centroid_x_o,
  output logic [13:0]      centroid_y_o,
  output logic [15:0]      mass_o,
  output logic [4:0]       blob_count_o,
  output logic             valid_res_o,
  output logic             overflow_o,
  output logic             last_o
);

  cmd_t    cmd;
  status_t status;

  lbct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lbct_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .pixel_i      (pixel_i),
    .column_i     (column_i),
    .line_i       (line_i),
    .line_start_i (line_start_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .centroid_x_o (centroid_x_o),
    .centroid_y_o (centroid_y_o),
    .mass_o       (mass_o),
    .blob_count_o (blob_count_o),
    .valid_res_o  (valid_res_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  // one item in flight: the controller leaves idle on every accepted beat
  `LBCT_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // an empty-frame beat is always the last of its frame
  `LBCT_ASSERT_IMP(a_empty_last, clk_i, rst_ni, out_valid_o && !valid_res_o, last_o)
  `LBCT_ASSERT_IMP(a_count_nz, clk_i, rst_ni, out_valid_o && valid_res_o, blob_count_o != 5'd0)

endmodule
`default_nettype wire

// ----- hdl/lbct_div.sv -----
// Restoring divider, one quotient bit per cycle
`default_nettype none
module lbct_div
  import lbct_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] num_i,
  input  wire logic [DIV_DW-1:0] den_i,
  output logic                   done_o,
  output logic [DIV_NW-1:0]      quot_o,
  output logic [DIV_DW-1:0]      rem_o
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] num_q, num_d;
  logic [DIV_DW-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_DW:0]   trial;

  always_comb begin
    trial  = {rem_q, num_q[DIV_NW-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIV_NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIV_DW'(trial - {1'b0, den_q});
        num_d = {num_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_DW-1:0];
        num_d = {num_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- hdl/lbct_datapath.sv -----
// Datapath: config, run tracking, blob map, segment store, accumulators, output
`default_nettype none
module lbct_datapath
  import lbct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  pixel_i,
  input  wire logic [9:0]  column_i,
  input  wire logic [9:0]  line_i,
  input  wire logic        line_start_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [13:0]      centroid_x_o,
  output logic [13:0]      centroid_y_o,
  output logic [15:0]      mass_o,
  output logic [4:0]       blob_count_o,
  output logic             valid_res_o,
  output logic             overflow_o,
  output logic             last_o,
  input  wire cmd_t        cmd_i,
  output status_t          status_o
);

  // configuration
  logic [10:0] lw_q, iv_q;
  logic [7:0]  thr_q;
  logic [5:0]  gmax_q;

  // latched item
  mode_e       mode_q;
  logic [7:0]  pix_q;
  logic [9:0]  col_q, line_q;
  logic        ls_q;

  // open run
  logic [5:0]        gap_q;
  logic [RUN_W-1:0]  rcnt_q;
  logic [RSUM_W-1:0] rsum_q;

  // blob map
  map_ent_t          map_mem [MAP_ENTRIES];
  map_ent_t          map_rd_q, map_wd, idc_q;
  logic              map_re, map_we;
  logic [MAP_IW-1:0] map_ra, map_wa, id_q, seg_p_q;
  logic [MAP_CW-1:0] used_q, i_q;
  logic              found_q;
  logic [XC_W-1:0]   xc_q;

  // segment store
  seg_ent_t          seg_mem [SEGMENT_ENTRIES];
  seg_ent_t          seg_rd_q;
  logic [SEG_CW-1:0] seg_used_q, j_q;

  // accumulators, valid bits stand for the zero reset value
  acc_ent_t          acc_mem [MAP_ENTRIES];
  acc_ent_t          acc_rd_q, acc_base, acc_wd;
  logic [MAP_ENTRIES-1:0] acc_vld_q;
  logic              acc_rd_vld_q, acc_re;
  logic [MAP_IW-1:0] acc_ra, acc_addr_q;
  logic [MAP_CW-1:0] count_q, p_q, k_q;
  logic              ovf_q;
  logic [16:0]       mass_sum;
  logic [XC_W-1:0]   qx_q;

  // output register
  logic        out_valid_q;
  logic [13:0] cx_q, cy_q;
  logic [15:0] mass_q;
  logic [4:0]  bc_q;
  logic        vres_q, ovfo_q, last_q;

  // divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den, div_rem;

  logic              lit, closing, col_ok, place_ok, last_res, out_free;
  logic signed [10:0] ydiff;
  logic              far, ovl;
  logic [16:0]       tol;
  logic [13:0]       wc2, wl2;

  lbct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_comb begin
    lit      = pix_q > thr_q;
    closing  = !lit && (gap_q < gmax_q) && ((gap_q + 6'd1) == gmax_q);
    col_ok   = (col_q != '0) && ({1'b0, col_q} < lw_q) &&
               (LP_W'(col_q) < LP_W'(LINE_PIXELS));
    place_ok = found_q || (used_q < MAP_CW'(MAP_ENTRIES));
    last_res = (k_q + 1'b1) == count_q;
    out_free = !out_valid_q || out_ready_i;

    // line distance is signed: an earlier line keeps the entry alive
    ydiff = $signed({1'b0, line_q}) - $signed({1'b0, map_rd_q.y});
    far   = ydiff > $signed({5'b0, gmax_q});
    wc2   = {rcnt_q[RUN_W-1:1], 4'b0};
    wl2   = {map_rd_q.w[RUN_W-1:1], 4'b0};
    tol   = 17'(wc2) + 17'(wl2) + 17'({gmax_q, 4'b0});
    ovl   = (17'(xc_q) + tol >= 17'(map_rd_q.x)) &&
            (17'(map_rd_q.x) + tol >= 17'(xc_q));

    div_start = cmd_i.mod_start || cmd_i.xc_start || cmd_i.divx_start || cmd_i.divy_start;
    div_num   = DIV_NW'(col_q - 10'd1);
    div_den   = (iv_q == '0) ? DIV_DW'(1) : iv_q;
    if (cmd_i.xc_start) begin
      div_num = {rsum_q, 4'b0};
      div_den = rcnt_q;
    end else if (cmd_i.divx_start) begin
      div_num = DIV_NW'(acc_rd_q.sx);
      div_den = DIV_DW'(acc_rd_q.n);
    end else if (cmd_i.divy_start) begin
      div_num = DIV_NW'(acc_rd_q.sy);
      div_den = DIV_DW'(acc_rd_q.n);
    end

    map_re = cmd_i.match_rd || cmd_i.acc_map_rd;
    map_ra = cmd_i.acc_map_rd ? seg_rd_q.i : i_q[MAP_IW-1:0];
    map_we = 1'b0;
    map_wa = i_q[MAP_IW-1:0];
    map_wd = map_rd_q;
    if (cmd_i.match_ev && map_rd_q.act) begin
      if (far) begin
        map_we     = 1'b1;
        map_wd.act = 1'b0;
      end else if (ovl && found_q && map_rd_q.sole) begin
        map_we      = 1'b1;
        map_wd      = idc_q;
        map_wd.sole = 1'b0;
      end
    end
    if (cmd_i.place) begin
      map_wd.x = xc_q;
      map_wd.w = rcnt_q;
      map_wd.y = line_q;
      if (found_q) begin
        map_we      = 1'b1;
        map_wa      = id_q;
        map_wd.p    = idc_q.p;
        map_wd.act  = idc_q.act;
        map_wd.sole = idc_q.sole;
      end else if (place_ok) begin
        map_we      = 1'b1;
        map_wa      = used_q[MAP_IW-1:0];
        map_wd.p    = used_q[MAP_IW-1:0];
        map_wd.act  = 1'b1;
        map_wd.sole = 1'b1;
      end
    end

    acc_re   = cmd_i.acc_rd || cmd_i.emit_rd;
    acc_ra   = cmd_i.emit_rd ? p_q[MAP_IW-1:0] : map_rd_q.p;
    acc_base = acc_rd_vld_q ? acc_rd_q : '0;
    mass_sum = {1'b0, acc_base.mass} + 17'(seg_rd_q.w);
    acc_wd.mass = mass_sum[16] ? 16'hFFFF : mass_sum[15:0];
    acc_wd.n    = acc_base.n + 1'b1;
    acc_wd.sx   = acc_base.sx + SUM_W'(seg_rd_q.x);
    acc_wd.sy   = acc_base.sy + SUM_W'({seg_rd_q.l, 4'b0});
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_ra];
    end
    if (cmd_i.seg_wr && (seg_used_q < SEG_CW'(SEGMENT_ENTRIES))) begin
      seg_mem[seg_used_q[SEG_IW-1:0]] <= '{i: seg_p_q, l: line_q, x: xc_q, w: rcnt_q};
    end
    if (cmd_i.acc_seg_rd) begin
      seg_rd_q <= seg_mem[j_q[SEG_IW-1:0]];
    end
    if (cmd_i.acc_wr) begin
      acc_mem[acc_addr_q] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_q   <= acc_mem[acc_ra];
      acc_addr_q <= acc_ra;
    end
    if (cmd_i.take) begin
      mode_q <= mode_e'(mode_i);
      pix_q  <= pixel_i;
      col_q  <= column_i;
      line_q <= line_i;
      ls_q   <= line_start_i;
    end
    if (cmd_i.match_init) begin
      xc_q <= div_quot[XC_W-1:0];
    end
    if (cmd_i.match_ev && map_rd_q.act && !far && ovl) begin
      if (!found_q) begin
        id_q  <= i_q[MAP_IW-1:0];
        idc_q <= map_rd_q;
      end else if (map_rd_q.sole) begin
        idc_q.sole <= 1'b0;
      end
    end
    if (cmd_i.place) begin
      seg_p_q <= found_q ? idc_q.p : used_q[MAP_IW-1:0];
    end
    if (cmd_i.divy_start) begin
      qx_q <= div_quot[XC_W-1:0];
    end
    if (cmd_i.out_load) begin
      cx_q   <= qx_q;
      cy_q   <= div_quot[13:0];
      mass_q <= acc_rd_q.mass;
      bc_q   <= 5'(count_q);
      vres_q <= 1'b1;
      ovfo_q <= ovf_q;
      last_q <= last_res;
    end else if (cmd_i.out_empty) begin
      cx_q   <= '0;
      cy_q   <= '0;
      mass_q <= '0;
      bc_q   <= '0;
      vres_q <= 1'b0;
      ovfo_q <= ovf_q;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q         <= 11'd1024;
      iv_q         <= 11'd1;
      thr_q        <= 8'd128;
      gmax_q       <= 6'd4;
      gap_q        <= 6'd4;
      rcnt_q       <= '0;
      rsum_q       <= '0;
      used_q       <= '0;
      i_q          <= '0;
      found_q      <= 1'b0;
      seg_used_q   <= '0;
      j_q          <= '0;
      acc_vld_q    <= '0;
      acc_rd_vld_q <= 1'b0;
      count_q      <= '0;
      p_q          <= '0;
      k_q          <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LINE_WIDTH:      lw_q   <= cfg_wdata_i;
          REG_SAMPLE_INTERVAL: iv_q   <= cfg_wdata_i;
          REG_PIXEL_THRESHOLD: thr_q  <= cfg_wdata_i[7:0];
          REG_MAX_GAP:         gmax_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end

      if (cmd_i.drop_run || cmd_i.clear_all || (cmd_i.drop_ls && ls_q)) begin
        gap_q  <= gmax_q;
        rcnt_q <= '0;
        rsum_q <= '0;
      end else if (cmd_i.pix_apply) begin
        if (lit) begin
          gap_q <= '0;
          if (rcnt_q < RUN_MAX) begin
            rcnt_q <= rcnt_q + 1'b1;
            rsum_q <= rsum_q + RSUM_W'(col_q);
          end
        end else if (gap_q < gmax_q) begin
          gap_q <= gap_q + 6'd1;
        end
      end

      if (cmd_i.match_init) begin
        i_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.match_ev) begin
        i_q <= i_q + 1'b1;
        if (map_rd_q.act && !far && ovl) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.place && !found_q) begin
        if (place_ok) begin
          used_q <= used_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.seg_wr) begin
        if (seg_used_q < SEG_CW'(SEGMENT_ENTRIES)) begin
          seg_used_q <= seg_used_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (cmd_i.acc_init) begin
        j_q       <= '0;
        p_q       <= '0;
        k_q       <= '0;
        count_q   <= '0;
        acc_vld_q <= '0;
      end
      if (cmd_i.acc_rd) begin
        acc_rd_vld_q <= acc_vld_q[map_rd_q.p];
      end
      if (cmd_i.emit_rd) begin
        acc_rd_vld_q <= acc_vld_q[p_q[MAP_IW-1:0]];
        p_q          <= p_q + 1'b1;
      end
      if (cmd_i.acc_wr) begin
        acc_vld_q[acc_addr_q] <= 1'b1;
        j_q                   <= j_q + 1'b1;
        if (!acc_rd_vld_q) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        k_q <= k_q + 1'b1;
      end

      if (cmd_i.clear_blobs || cmd_i.clear_all) begin
        used_q     <= '0;
        seg_used_q <= '0;
        acc_vld_q  <= '0;
        count_q    <= '0;
        ovf_q      <= 1'b0;
      end

      if (cmd_i.out_load || cmd_i.out_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.mode       = mode_q;
    status_o.col_ok     = col_ok;
    status_o.div_done   = div_done;
    status_o.mod_zero   = div_rem == '0;
    status_o.closing    = closing;
    status_o.run_empty  = rcnt_q == '0;
    status_o.match_more = i_q < used_q;
    status_o.place_ok   = place_ok;
    status_o.acc_more   = j_q < seg_used_q;
    status_o.count_zero = count_q == '0;
    status_o.emit_more  = p_q < MAP_CW'(MAP_ENTRIES);
    status_o.emit_vld   = acc_rd_vld_q;
    status_o.out_free   = out_free;
    status_o.last_res   = last_res;
  end

  assign out_valid_o  = out_valid_q;
  assign centroid_x_o = cx_q;
  assign centroid_y_o = cy_q;
  assign mass_o       = mass_q;
  assign blob_count_o = bc_q;
  assign valid_res_o  = vres_q;
  assign overflow_o   = ovfo_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// ----- hdl/lbct_ctrl.sv -----
// Controller state machine of the blob centroid tracker
`default_nettype none
module lbct_ctrl
  import lbct_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status_i.mode)
          MODE_PIXEL: state_d = ST_CHECK;
          MODE_EOF:   state_d = ST_ACC_SEG_RD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_CHECK:    state_d = status_i.col_ok ? ST_MOD_WAIT : ST_IDLE;
      ST_MOD_WAIT: if (status_i.div_done) state_d = ST_PIXEL;
      ST_PIXEL: begin
        if (status_i.mod_zero && status_i.closing && !status_i.run_empty) begin
          state_d = ST_XC_WAIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_XC_WAIT:  if (status_i.div_done) state_d = ST_MATCH_RD;
      ST_MATCH_RD: state_d = status_i.match_more ? ST_MATCH_EV : ST_PLACE;
      ST_MATCH_EV: state_d = ST_MATCH_RD;
      ST_PLACE:    state_d = status_i.place_ok ? ST_SEG : ST_IDLE;
      ST_SEG:      state_d = ST_IDLE;
      ST_ACC_SEG_RD: state_d = status_i.acc_more ? ST_ACC_MAP_RD : ST_EMIT_RD;
      ST_ACC_MAP_RD: state_d = ST_ACC_RD;
      ST_ACC_RD:     state_d = ST_ACC_WR;
      ST_ACC_WR:     state_d = ST_ACC_SEG_RD;
      ST_EMIT_RD: begin
        if (status_i.count_zero) begin
          state_d = ST_OUT_EMPTY;
        end else if (status_i.emit_more) begin
          state_d = ST_EMIT_CHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_CHK:  state_d = status_i.emit_vld ? ST_DIVX_WAIT : ST_EMIT_RD;
      ST_DIVX_WAIT: if (status_i.div_done) state_d = ST_DIVY_WAIT;
      ST_DIVY_WAIT: if (status_i.div_done) state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_res ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_OUT_EMPTY: if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_DISPATCH: begin
        case (status_i.mode)
          MODE_PIXEL: cmd_o.drop_ls   = 1'b1;
          MODE_EOF:   cmd_o.acc_init  = 1'b1;
          MODE_CLEAR: cmd_o.clear_all = 1'b1;
          default: ;
        endcase
      end
      ST_CHECK: cmd_o.mod_start = status_i.col_ok;
      ST_PIXEL: begin
        if (status_i.mod_zero) begin
          cmd_o.pix_apply = 1'b1;
          if (status_i.closing) begin
            // an empty run closes with nothing to record
            cmd_o.drop_run = status_i.run_empty;
            cmd_o.xc_start = !status_i.run_empty;
          end
        end
      end
      ST_XC_WAIT:  cmd_o.match_init = status_i.div_done;
      ST_MATCH_RD: cmd_o.match_rd   = status_i.match_more;
      ST_MATCH_EV: cmd_o.match_ev   = 1'b1;
      ST_PLACE: begin
        cmd_o.place    = 1'b1;
        cmd_o.drop_run = !status_i.place_ok;
      end
      ST_SEG: begin
        cmd_o.seg_wr   = 1'b1;
        cmd_o.drop_run = 1'b1;
      end
      ST_ACC_SEG_RD: cmd_o.acc_seg_rd = status_i.acc_more;
      ST_ACC_MAP_RD: cmd_o.acc_map_rd = 1'b1;
      ST_ACC_RD:     cmd_o.acc_rd     = 1'b1;
      ST_ACC_WR:     cmd_o.acc_wr     = 1'b1;
      ST_EMIT_RD: begin
        if (!status_i.count_zero) begin
          cmd_o.emit_rd     = status_i.emit_more;
          cmd_o.clear_blobs = !status_i.emit_more;
        end
      end
      ST_EMIT_CHK:  cmd_o.divx_start = status_i.emit_vld;
      ST_DIVX_WAIT: cmd_o.divy_start = status_i.div_done;
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.clear_blobs = status_i.last_res;
        end
      end
      ST_OUT_EMPTY: begin
        cmd_o.out_empty   = status_i.out_free;
        cmd_o.clear_blobs = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
